// ----- rtl/gsrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsrs_pkg: shared types and constants for the grid scan running stats core
// Register indexes, default sizes and controller-to-datapath command structs.
// ----------------------------------------------------------------------------
package gsrs_pkg;

    localparam int DEF_MAX_DELAY_POINTS = 64;
    localparam int DEF_MAX_FREQ_POINTS  = 64;
    localparam int DEF_VALUE_WIDTH      = 32;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_NUM_DELAY = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NUM_FREQ  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHOTS     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FREQ_1ST  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_STOP      = 3'd4;

    localparam int COUNT_WIDTH = 24;
    localparam int SUMSQ_WIDTH = 64;

    // controller -> datapath commands
    typedef struct packed {
        logic clr_pass;    // write zero at the sweep address
        logic load;        // capture shot, issue store read
        logic calc;        // compute delta and start divider
        logic mul;         // form |delta|*|resid| partial products
        logic acc;         // accumulate the product chunk
        logic wr;          // write point back, present result
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic mul_last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/grid_scan_running_stats_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_scan_running_stats_core: Welford running mean/variance over a 2D scan
// Each accepted shot runs load, read, a bit-serial divide, a chunked
// multiply and write-back before the result strobe; no new shot is taken
// while busy. A dropped shot is strobed through the drop register instead.
// Reset: a clearing pass over MAX_DELAY_POINTS*MAX_FREQ_POINTS addresses
// zeroes the point stores; busy stays high through it. The receiver cannot stall.
// ----------------------------------------------------------------------------
module grid_scan_running_stats_core #(
    parameter int MAX_DELAY_POINTS = gsrs_pkg::DEF_MAX_DELAY_POINTS,
    parameter int MAX_FREQ_POINTS  = gsrs_pkg::DEF_MAX_FREQ_POINTS,
    parameter int VALUE_WIDTH      = gsrs_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [gsrs_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
    input  wire logic [gsrs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] shot_value,
    output logic             result_valid,
    output logic             accepted,
    output logic             point_advanced,
    output logic [5:0]       updated_delay_index,
    output logic [5:0]       updated_freq_index,
    output logic [23:0]      point_count,
    output logic [31:0]      point_mean,
    output logic [63:0]      point_sum_sq,
    output logic             scan_complete
);

    gsrs_pkg::dp_cmd_t cmd;
    gsrs_pkg::dp_sts_t sts;
    logic drop_now, drop_res;

    gsrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .drop(drop_now),
        .busy(busy), .drop_out(drop_res), .cmd(cmd), .sts(sts)
    );

    gsrs_dpath #(
        .MAX_DELAY_POINTS(MAX_DELAY_POINTS),
        .MAX_FREQ_POINTS(MAX_FREQ_POINTS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .shot_in(shot_value), .cmd(cmd), .drop_res(drop_res),
        .sts(sts), .drop_now(drop_now), .res_valid(result_valid),
        .res_accepted(accepted), .res_advanced(point_advanced),
        .res_delay(updated_delay_index), .res_freq(updated_freq_index),
        .res_count(point_count), .res_mean(point_mean),
        .res_sumsq(point_sum_sq), .res_complete(scan_complete)
    );

    // every write-back is followed by a result strobe
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.wr) |-> result_valid)
        else $error("result strobe missing after write-back");

    a_no_start_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.calc || cmd.mul || cmd.acc) |-> busy)
        else $error("datapath working while not busy");

    a_drop_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !accepted) |-> scan_complete)
        else $error("dropped shot without complete flag");

    a_onehot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_pass, cmd.load, cmd.calc, cmd.mul, cmd.acc, cmd.wr}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ----- rtl/gsrs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsrs_ram: generic simple dual port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module gsrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/gsrs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsrs_ctrl: controller for the grid scan running stats core
// Sequences the clearing pass, read, divide, multiply and write-back.
// ----------------------------------------------------------------------------
module gsrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              drop,
    output logic                   busy,
    output logic                   drop_out,
    output gsrs_pkg::dp_cmd_t      cmd,
    input  wire gsrs_pkg::dp_sts_t sts
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_WR    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   drop_reg, drop_next;

    always_comb
    begin
        state_next = state_reg;
        drop_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_pass = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // a dropped transaction holds busy through the drop register
                if (start && !drop_reg)
                begin
                    if (drop)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.mul_last ? ST_WR : ST_MUL;
            end
            ST_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE) || drop_reg;
    assign drop_out = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gsrs_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsrs_dpath: datapath for the grid scan running stats core
// Point stores, serial divider, chunked multiplier, scan indices.
// ----------------------------------------------------------------------------
module gsrs_dpath #(
    parameter int MAX_DELAY_POINTS = gsrs_pkg::DEF_MAX_DELAY_POINTS,
    parameter int MAX_FREQ_POINTS  = gsrs_pkg::DEF_MAX_FREQ_POINTS,
    parameter int VALUE_WIDTH      = gsrs_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [gsrs_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
    input  wire logic [gsrs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  wire logic [31:0]            shot_in,
    input  wire gsrs_pkg::dp_cmd_t      cmd,
    input  wire logic                   drop_res,
    output gsrs_pkg::dp_sts_t           sts,
    output logic                        drop_now,
    output logic                        res_valid,
    output logic                        res_accepted,
    output logic                        res_advanced,
    output logic [5:0]                  res_delay,
    output logic [5:0]                  res_freq,
    output logic [23:0]                 res_count,
    output logic [31:0]                 res_mean,
    output logic [63:0]                 res_sumsq,
    output logic                        res_complete
);

    localparam int DW    = (MAX_DELAY_POINTS > 1) ? $clog2(MAX_DELAY_POINTS) : 1;
    localparam int FW    = (MAX_FREQ_POINTS > 1) ? $clog2(MAX_FREQ_POINTS) : 1;
    localparam int DEPTH = MAX_DELAY_POINTS * MAX_FREQ_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int MW    = VALUE_WIDTH;            // stored mean width
    localparam int DLW   = IW + 2;                 // delta width, signed
    localparam int CW    = gsrs_pkg::COUNT_WIDTH;
    localparam int SW    = gsrs_pkg::SUMSQ_WIDTH;
    localparam int QW    = DLW + 1;                // divider bits
    localparam int QCW   = $clog2(QW + 1);
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    // configuration
    logic [6:0]  nd_cfg_reg, nf_cfg_reg;
    logic [15:0] spp_cfg_reg;
    logic        ffirst_reg, stop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_cfg_reg  <= 7'd1;
            nf_cfg_reg  <= 7'd1;
            spp_cfg_reg <= 16'd1;
            ffirst_reg  <= 1'b0;
            stop_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                gsrs_pkg::REG_NUM_DELAY: nd_cfg_reg  <= cfg_data[6:0];
                gsrs_pkg::REG_NUM_FREQ:  nf_cfg_reg  <= cfg_data[6:0];
                gsrs_pkg::REG_SHOTS:     spp_cfg_reg <= cfg_data;
                gsrs_pkg::REG_FREQ_1ST:  ffirst_reg  <= cfg_data[0];
                gsrs_pkg::REG_STOP:      stop_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped point counts, 11 bits covers the parameter range
    logic [10:0] nd_eff, nf_eff;
    always_comb
    begin
        nd_eff = {4'd0, nd_cfg_reg};
        if (nd_cfg_reg == 7'd0) nd_eff = 11'd1;
        else if ({4'd0, nd_cfg_reg} > 11'(MAX_DELAY_POINTS)) nd_eff = 11'(MAX_DELAY_POINTS);
        nf_eff = {4'd0, nf_cfg_reg};
        if (nf_cfg_reg == 7'd0) nf_eff = 11'd1;
        else if ({4'd0, nf_cfg_reg} > 11'(MAX_FREQ_POINTS)) nf_eff = 11'(MAX_FREQ_POINTS);
    end

    // scan state
    logic [DW-1:0] di_reg, di_next;
    logic [FW-1:0] fi_reg, fi_next;
    logic [15:0]   visit_reg, visit_next;
    logic          done_reg, done_next;
    logic          adv;

    assign drop_now = done_reg && stop_reg;

    always_comb
    begin
        logic [15:0] v1;
        logic        dlast, flast;
        v1        = visit_reg + 16'd1;
        dlast     = ({{(11-DW){1'b0}}, di_reg} + 11'd1) >= nd_eff;
        flast     = ({{(11-FW){1'b0}}, fi_reg} + 11'd1) >= nf_eff;
        adv       = (v1 >= spp_cfg_reg) || (v1 == 16'd0);
        di_next   = di_reg;
        fi_next   = fi_reg;
        done_next = done_reg;
        visit_next = adv ? 16'd0 : v1;
        if (adv)
        begin
            if (dlast && flast) done_next = 1'b1;
            if (ffirst_reg)
            begin
                if (flast) di_next = dlast ? '0 : di_reg + DW'(1);
                fi_next = flast ? '0 : fi_reg + FW'(1);
            end
            else
            begin
                if (dlast) fi_next = flast ? '0 : fi_reg + FW'(1);
                di_next = dlast ? '0 : di_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            di_reg    <= '0;
            fi_reg    <= '0;
            visit_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (cmd.wr)
        begin
            di_reg    <= di_next;
            fi_reg    <= fi_next;
            visit_reg <= visit_next;
            done_reg  <= done_next;
        end
    end

    // clearing sweep
    logic [AW:0] clr_reg;
    assign sts.clr_last = cmd.clr_pass && (clr_reg == (AW+1)'(DEPTH - 1));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_pass)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // stores
    logic [AW-1:0] addr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [CW-1:0] cnt_rd, cnt_wd;
    logic [MW-1:0] mean_rd, mean_wd;
    logic [SW-1:0] ssq_rd, ssq_wd;

    assign addr  = AW'(di_reg) * AW'(MAX_FREQ_POINTS) + AW'(fi_reg);
    assign we    = cmd.clr_pass || cmd.wr;
    assign waddr = cmd.clr_pass ? clr_reg[AW-1:0] : addr;

    gsrs_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt (
        .clk(clk), .we(we), .waddr(waddr), .wdata(cnt_wd), .raddr(addr), .rdata(cnt_rd));
    gsrs_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_mean (
        .clk(clk), .we(we), .waddr(waddr), .wdata(mean_wd), .raddr(addr), .rdata(mean_rd));
    gsrs_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ssq (
        .clk(clk), .we(we), .waddr(waddr), .wdata(ssq_wd), .raddr(addr), .rdata(ssq_rd));

    // working registers
    logic signed [IW-1:0]  x_reg;
    logic [CW-1:0]         n_reg;
    logic signed [MW-1:0]  mold_reg, mnew_reg;
    logic [SW-1:0]         ssq_reg;
    logic                  dneg_reg;
    logic [DLW-1:0]        amag_reg, bmag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= signed'(shot_in[IW-1:0]);
        end
    end

    // serial restoring divider on magnitudes: |delta| / n
    logic [QW-1:0]  quo_reg;
    logic [CW:0]    rem_reg;
    logic [QCW-1:0] qcnt_reg;
    logic           div_run_reg;

    logic signed [DLW-1:0] delta_c;
    logic [CW-1:0]         n_c;
    assign n_c     = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + CW'(1);
    assign delta_c = DLW'(x_reg) - DLW'(signed'(mean_rd));

    // QW steps, then one cycle with the finished quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg <= 1'b0;
            qcnt_reg    <= '0;
        end
        else if (cmd.calc)
        begin
            div_run_reg <= 1'b1;
            qcnt_reg    <= QCW'(QW);
        end
        else if (div_run_reg)
        begin
            if (qcnt_reg == '0) div_run_reg <= 1'b0;
            else qcnt_reg <= qcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CW:0] trial;
        if (cmd.calc)
        begin
            n_reg    <= n_c;
            mold_reg <= signed'(mean_rd);
            ssq_reg  <= ssq_rd;
            dneg_reg <= delta_c[DLW-1];
            amag_reg <= delta_c[DLW-1] ? DLW'(-delta_c) : DLW'(delta_c);
            quo_reg  <= QW'(delta_c[DLW-1] ? DLW'(-delta_c) : DLW'(delta_c));
            rem_reg  <= '0;
        end
        else if (div_run_reg && (qcnt_reg != '0))
        begin
            trial = {rem_reg[CW-1:0], quo_reg[QW-1]};
            if (trial >= {1'b0, n_reg})
            begin
                rem_reg <= trial - {1'b0, n_reg};
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = div_run_reg && (qcnt_reg == '0);

    // mean update and residual magnitude after division
    logic signed [DLW:0] mnew_c, resid_c;
    logic [DLW-1:0]      qmag;
    assign qmag    = DLW'(quo_reg);
    assign mnew_c  = (DLW+1)'(mold_reg) + (dneg_reg ? -(DLW+1)'(qmag) : (DLW+1)'(qmag));
    assign resid_c = (DLW+1)'(x_reg) - mnew_c;

    logic mul_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_first_reg <= 1'b1;
        end
        else if (sts.div_done)
        begin
            mul_first_reg <= 1'b1;
        end
        else if (cmd.acc)
        begin
            mul_first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.div_done)
        begin
            mnew_reg <= MW'(mnew_c);
            bmag_reg <= resid_c[DLW] ? DLW'(-resid_c) : DLW'(resid_c);
        end
    end

    // product |delta|*|resid| in two chunks of b (low half, then high half)
    localparam int HW = (DLW + 1) / 2;
    localparam int PW = DLW + HW;
    logic [PW-1:0]       pp_reg;
    logic [2*DLW-1:0]    prod_reg;
    logic [HW-1:0]       bchunk;
    assign bchunk       = mul_first_reg ? bmag_reg[HW-1:0] : HW'(bmag_reg >> HW);
    assign sts.mul_last = !mul_first_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pp_reg <= PW'(amag_reg) * PW'(bchunk);
        end
        if (cmd.acc)
        begin
            if (mul_first_reg) prod_reg <= (2*DLW)'(pp_reg);
            else prod_reg <= prod_reg + ((2*DLW)'(pp_reg) << HW);
        end
    end

    // saturating sum
    logic [SW:0]   ssum;
    logic [SW-1:0] prod_sat;
    always_comb
    begin
        if (2*DLW > SW && |(prod_reg >> SW)) prod_sat = {SW{1'b1}};
        else prod_sat = SW'(prod_reg);
        ssum = {1'b0, ssq_reg} + {1'b0, prod_sat};
    end

    assign cnt_wd  = cmd.clr_pass ? '0 : n_reg;
    assign mean_wd = cmd.clr_pass ? '0 : mnew_reg;
    assign ssq_wd  = cmd.clr_pass ? '0 : (ssum[SW] ? {SW{1'b1}} : ssum[SW-1:0]);

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= cmd.wr || drop_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            res_accepted <= 1'b1;
            res_advanced <= adv;
            res_delay    <= 6'(di_reg);
            res_freq     <= 6'(fi_reg);
            res_count    <= n_reg;
            res_mean     <= 32'(mnew_reg);
            res_sumsq    <= ssq_wd;
            res_complete <= done_next;
        end
        else if (drop_res)
        begin
            res_accepted <= 1'b0;
            res_advanced <= 1'b0;
            res_delay    <= '0;
            res_freq     <= '0;
            res_count    <= '0;
            res_mean     <= '0;
            res_sumsq    <= '0;
            res_complete <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- tb/grid_scan_running_stats_checker.sv -----
// ----------------------------------------------------------------------------
// grid_scan_running_stats_checker: shot-by-shot scoreboard for the scan core
// Follows register writes and shots started while idle, keeps a copy of the
// grid position and the per-point Welford statistics. It checks each result
// strobe, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module grid_scan_running_stats_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [gsrs_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
    input  logic [gsrs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] shot_value,
    input  logic        result_valid,
    input  logic        accepted,
    input  logic        point_advanced,
    input  logic [5:0]  updated_delay_index,
    input  logic [5:0]  updated_freq_index,
    input  logic [23:0] point_count,
    input  logic [31:0] point_mean,
    input  logic [63:0] point_sum_sq,
    input  logic        scan_complete,
    output int          errors,
    output int          pending
);

    localparam int NPTS = 64;

    typedef struct packed {
        logic        accepted;
        logic        advanced;
        logic [5:0]  d_idx;
        logic [5:0]  f_idx;
        logic [23:0] count;
        logic [31:0] mean;
        logic [63:0] sum_sq;
        logic        complete;
    } point_stats_t;

    // register copies
    logic [6:0]  n_delay, n_freq;
    logic [15:0] shots_cfg;
    logic        freq_first, stop_mode;
    // scan position
    logic [5:0]  delay_pos, freq_pos;
    logic [15:0] visit_cnt;
    logic        done_flag;
    // per-point statistics
    logic [23:0] count_mem [NPTS*NPTS];
    longint      mean_mem  [NPTS*NPTS];
    logic [63:0] sumsq_mem [NPTS*NPTS];

    point_stats_t expected_stats[$];

    assign pending = expected_stats.size();

    function automatic logic [6:0] clamp_pts(logic [6:0] v);
        if (v == 0) return 7'd1;
        if (v > NPTS) return 7'(NPTS);
        return v;
    endfunction

    task automatic predict_shot(input logic [31:0] raw);
        point_stats_t r;
        logic [6:0]   nd, nf;
        logic [16:0]  spp;
        logic [5:0]   di, fi;
        logic [11:0]  addr;
        logic [23:0]  n;
        longint       x, mu, delta, resid;
        logic [63:0]  a, b, prod, ss;
        logic [127:0] wide;
        logic [64:0]  sum65;
        r = '0;
        nd = clamp_pts(n_delay);
        nf = clamp_pts(n_freq);
        spp = (shots_cfg == 0) ? 17'd1 : {1'b0, shots_cfg};
        if (done_flag && stop_mode) begin
            r.complete = 1'b1;
            expected_stats.push_back(r);
            return;
        end
        di = delay_pos;
        fi = freq_pos;
        addr = {di, fi};
        x = $signed(raw);
        n = count_mem[addr];
        if (n != 24'hFFFFFF) n = n + 24'd1;
        mu = mean_mem[addr];
        delta = x - mu;
        mu = mu + delta / longint'({40'b0, n});
        resid = x - mu;
        a = delta[63] ? -delta : delta;
        b = resid[63] ? -resid : resid;
        wide = {64'b0, a} * {64'b0, b};
        prod = (|wide[127:64]) ? '1 : wide[63:0];
        sum65 = {1'b0, sumsq_mem[addr]} + {1'b0, prod};
        ss = sum65[64] ? '1 : sum65[63:0];
        count_mem[addr] = n;
        mean_mem[addr]  = mu;
        sumsq_mem[addr] = ss;

        visit_cnt = visit_cnt + 16'd1;
        if ({1'b0, visit_cnt} >= spp || visit_cnt == 0) begin
            r.advanced = 1'b1;
            visit_cnt = '0;
            if (7'(di) + 1 >= nd && 7'(fi) + 1 >= nf) done_flag = 1'b1;
            if (freq_first) begin
                if (7'(fi) + 1 >= nf) di = (7'(di) + 1 >= nd) ? 6'd0 : di + 6'd1;
                fi = (7'(fi) + 1 >= nf) ? 6'd0 : fi + 6'd1;
            end
            else begin
                if (7'(di) + 1 >= nd) fi = (7'(fi) + 1 >= nf) ? 6'd0 : fi + 6'd1;
                di = (7'(di) + 1 >= nd) ? 6'd0 : di + 6'd1;
            end
            delay_pos = di;
            freq_pos = fi;
        end
        r.accepted = 1'b1;
        r.d_idx    = addr[11:6];
        r.f_idx    = addr[5:0];
        r.count    = n;
        r.mean     = mu[31:0];
        r.sum_sq   = ss;
        r.complete = done_flag;
        expected_stats.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        point_stats_t e;
        if (!rst_n) begin
            n_delay = 7'd1;
            n_freq = 7'd1;
            shots_cfg = 16'd1;
            freq_first = 1'b0;
            stop_mode = 1'b1;
            delay_pos = '0;
            freq_pos = '0;
            visit_cnt = '0;
            done_flag = 1'b0;
            for (int i = 0; i < NPTS*NPTS; i++) begin
                count_mem[i] = '0;
                mean_mem[i] = 0;
                sumsq_mem[i] = '0;
            end
        end
        else begin
            if (result_valid) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: result strobe with no transaction pending", $time);
                    errors++;
                end
                else begin
                    e = expected_stats.pop_front();
                    check_field("accepted", e.accepted, accepted);
                    check_field("point_advanced", e.advanced, point_advanced);
                    check_field("updated_delay_index", e.d_idx, updated_delay_index);
                    check_field("updated_freq_index", e.f_idx, updated_freq_index);
                    check_field("point_count", e.count, point_count);
                    check_field("point_mean", e.mean, point_mean);
                    check_field("point_sum_sq", e.sum_sq, point_sum_sq);
                    check_field("scan_complete", e.complete, scan_complete);
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    gsrs_pkg::REG_NUM_DELAY: n_delay = cfg_data[6:0];
                    gsrs_pkg::REG_NUM_FREQ:  n_freq = cfg_data[6:0];
                    gsrs_pkg::REG_SHOTS:     shots_cfg = cfg_data;
                    gsrs_pkg::REG_FREQ_1ST:  freq_first = cfg_data[0];
                    gsrs_pkg::REG_STOP:      stop_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy) predict_shot(shot_value);
        end
    end

    initial errors = 0;

endmodule

// ----- tb/grid_scan_running_stats_core_tb.sv -----
// ----------------------------------------------------------------------------
// grid_scan_running_stats_core_tb: top-level bench for the grid scan core
// Directed shots at the value extremes, stop and continue modes, register
// values out of range and a grid shrunk mid-scan, then random scans under
// random start gaps. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module grid_scan_running_stats_core_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [gsrs_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx = '0;
    logic [gsrs_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] shot_value = '0;
    logic        result_valid, accepted, point_advanced, scan_complete;
    logic [5:0]  updated_delay_index, updated_freq_index;
    logic [23:0] point_count;
    logic [31:0] point_mean;
    logic [63:0] point_sum_sq;
    int          errors, pending;
    int          shots_sent = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    grid_scan_running_stats_core dut (.*);

    grid_scan_running_stats_checker u_checker (.*);

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [gsrs_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [gsrs_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // all results in and core idle; leaves us on a rising edge
    task automatic drain;
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        @(posedge clk);
    endtask

    task automatic setup_scan(input logic [15:0] nd, input logic [15:0] nf,
                              input logic [15:0] spp, input logic ff, input logic stop);
        drain();
        write_reg(gsrs_pkg::REG_NUM_DELAY, nd);
        write_reg(gsrs_pkg::REG_NUM_FREQ, nf);
        write_reg(gsrs_pkg::REG_SHOTS, spp);
        write_reg(gsrs_pkg::REG_FREQ_1ST, {$urandom_range(32767), ff});
        write_reg(gsrs_pkg::REG_STOP, {$urandom_range(32767), stop});
        cfg_we <= 1'b0;
    endtask

    task automatic send_shot(input logic [31:0] v);
        int gap;
        shot_value <= v;
        start <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
        shots_sent++;
        // no gaps through the middle stretch
        if (!(shots_sent > 400 && shots_sent < 560) && $urandom_range(99) < 29) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            shot_value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_shot();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(255) - 128;
            3: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_scan(input int shots);
        setup_scan($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 8)),
                   $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 8)),
                   16'($urandom_range(0, 4)), $urandom_range(1), $urandom_range(4) == 0);
        repeat (shots) send_shot(rand_shot());
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stop mode: finish a 2x2 grid, later shots are dropped
        setup_scan(2, 2, 1, 1'b0, 1'b1);
        send_shot(32'h7FFF_FFFF);
        send_shot(32'h8000_0000);
        send_shot(32'h0000_0000);
        send_shot(32'h0000_0001);
        send_shot(32'hFFFF_FFFF);
        send_shot(32'h1234_5678);

        // zero point counts act as one; alternate extremes to saturate sum_sq
        setup_scan(0, 0, 0, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++) send_shot(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);

        // oversize counts clamp to the maximum grid; walk far into it
        setup_scan(16'hFFFF, 127, 1, 1'b0, 1'b0);
        repeat (40) send_shot(rand_shot());
        setup_scan(64, 64, 1, 1'b1, 1'b0);
        repeat (40) send_shot(rand_shot());

        // shrink the grid under a position past its end
        setup_scan(3, 2, 2, 1'b0, 1'b0);
        repeat (20) send_shot(rand_shot());

        // longest visit, a few shots only
        setup_scan(5, 5, 16'hFFFF, 1'b1, 1'b0);
        repeat (10) send_shot(rand_shot());

        repeat (7) random_scan(130);

        setup_scan(2, 3, 3, 1'b1, 1'b1);
        repeat (24) send_shot(rand_shot());

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
